FILE: src/md5_hash_engine_unit_assert.svh
// Assertion macros for the md5 engine checker.
`ifndef MD5_HASH_ENGINE_UNIT_ASSERT_SVH
`define MD5_HASH_ENGINE_UNIT_ASSERT_SVH

// Implication checked on every edge outside reset.
`define MD5_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every edge outside reset.
`define MD5_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/md5_pkg.sv
package md5_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  localparam int unsigned QueueDepthDef = 4;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word index used by round r.
  function automatic logic [3:0] round_w(input logic [5:0] r);
    logic [3:0] w;
    case (r[5:4])
      2'd0: w = r[3:0];
      2'd1: w = 4'((r[3:0] << 2) + r[3:0] + 4'd1);
      2'd2: w = 4'((r[3:0] << 1) + r[3:0] + 4'd5);
      default: w = 4'((r[3:0] << 3) - r[3:0]);
    endcase
    return w;
  endfunction

endpackage

FILE: src/md5_ram.sv
module md5_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: src/md5_queue.sv
module md5_queue import md5_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  md5_in_t push_data,
  output logic    full,
  input  logic    pop,
  output md5_in_t pop_data,
  output logic    empty
);
  localparam int unsigned Aw = $clog2(Depth);

  md5_in_t       slot_r [Depth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0]   cnt_r;

  assign full     = (cnt_r == (Aw+1)'(Depth));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wp_r] <= push_data;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == Aw'(Depth - 1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty) rp_r <= (rp_r == Aw'(Depth - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (Aw+1)'(push && !full) - (Aw+1)'(pop && !empty);
    end
  end
endmodule

FILE: src/md5_core.sv
module md5_core import md5_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  md5_in_t  q_data,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output md5_out_t out_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_PADSET, S_PADFILL, S_LEN, S_LOAD, S_ROUND, S_FOLD, S_OUT
  } state_t;

  state_t      state_r;
  logic [5:0]  fill_r;
  logic [63:0] len_r;
  logic [31:0] h_r [4];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  rnd_r;
  logic [31:0] m_r [16];
  logic        pad_r, second_r;
  logic [2:0]  lb_r;
  logic [1:0]  oi_r;
  logic [7:0]  byte_r;
  logic        last_r;

  logic        we;
  logic [5:0]  wa, ra;
  logic [7:0]  wd, rd;
  logic        ld_ph_r;

  md5_ram #(.Width(8), .Depth(64)) u_buf (
    .clk, .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
  );

  logic [31:0] fv, t, rot;
  logic [4:0]  sh;
  always_comb begin
    case (rnd_r[5:4])
      2'd0: fv = (b_r & c_r) | (~b_r & d_r);
      2'd1: fv = (b_r & d_r) | (c_r & ~d_r);
      2'd2: fv = b_r ^ c_r ^ d_r;
      default: fv = c_r ^ (b_r | ~d_r);
    endcase
    t   = a_r + fv + round_k(rnd_r) + m_r[round_w(rnd_r)];
    sh  = round_s(rnd_r);
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  // Byte address being loaded; the RAM read is registered, so data trails it.
  logic [5:0] lda_r;

  always_comb begin
    we = 1'b0;
    wa = fill_r;
    wd = byte_r;
    case (state_r)
      S_WRITE:   we = 1'b1;
      S_PADSET:  begin we = 1'b1; wd = PadByte; end
      S_PADFILL: begin we = 1'b1; wd = 8'h00; end
      S_LEN:     begin we = 1'b1; wa = {3'b111, lb_r}; wd = len_r[{lb_r, 3'b000} +: 8]; end
      default:   we = 1'b0;
    endcase
    ra = lda_r;
  end

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_valid = (state_r == S_OUT);
  assign out_data  = '{digest_word: h_r[oi_r], word_index: oi_r, last_word: (oi_r == 2'd3)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      h_r     <= '{InitA, InitB, InitC, InitD};
      oi_r    <= '0;
      pad_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (!q_empty) begin
          byte_r <= q_data.msg_byte;
          last_r <= q_data.last;
          if (q_data.has_byte) state_r <= S_WRITE;
          else if (q_data.last) state_r <= S_PADSET;
        end
        S_WRITE: begin
          fill_r <= fill_r + 6'd1;
          len_r  <= len_r + 64'd8;
          if (fill_r == 6'd63) begin
            pad_r <= 1'b0;
            lda_r <= '0; ld_ph_r <= 1'b0;
            state_r <= S_LOAD;
          end else if (last_r) state_r <= S_PADSET;
          else state_r <= S_IDLE;
        end
        S_PADSET: begin
          fill_r <= fill_r + 6'd1;
          second_r <= (fill_r >= 6'd56);
          pad_r <= 1'b1;
          lda_r <= '0; ld_ph_r <= 1'b0;
          if (fill_r == 6'd63) begin
            second_r <= 1'b1;
            state_r <= S_LOAD;
          end else if (fill_r == 6'd55) begin
            // pad byte lands right before the length field
            lb_r <= '0; state_r <= S_LEN;
          end else state_r <= S_PADFILL;
        end
        S_PADFILL: begin
          // zero up to byte 56, or to the block end when it must flush first
          fill_r <= fill_r + 6'd1;
          if (!second_r && fill_r == 6'd55) begin
            lb_r <= '0; state_r <= S_LEN;
          end else if (second_r && fill_r == 6'd63) begin
            lda_r <= '0; ld_ph_r <= 1'b0; state_r <= S_LOAD;
          end
        end
        S_LEN: begin
          lb_r <= lb_r + 3'd1;
          if (lb_r == 3'd7) begin
            second_r <= 1'b0;
            lda_r <= '0; ld_ph_r <= 1'b0; state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // reads are registered: data for address lda-1 arrives now
          lda_r <= lda_r + 6'd1;
          ld_ph_r <= 1'b1;
          if (ld_ph_r) begin
            logic [5:0] pa;
            pa = lda_r - 6'd1;
            m_r[pa[5:2]][{pa[1:0], 3'b000} +: 8] <= rd;
            if (pa == 6'd63) begin
              a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
              rnd_r <= '0; state_r <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r;
          b_r <= b_r + rot;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) state_r <= S_FOLD;
        end
        S_FOLD: begin
          h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r; h_r[3] <= h_r[3] + d_r;
          fill_r <= '0;
          // a full block closed by its last byte still needs the padding block
          if (!pad_r) state_r <= last_r ? S_PADSET : S_IDLE;
          else if (second_r) begin
            // flushed the overflow block; zero a fresh one up to the length
            second_r <= 1'b0; state_r <= S_PADFILL;
          end else begin
            oi_r <= '0; state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) begin
          oi_r <= oi_r + 2'd1;
          if (oi_r == 2'd3) begin
            h_r <= '{InitA, InitB, InitC, InitD};
            len_r <= '0; fill_r <= '0; pad_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/md5_hash_engine_unit.sv
// Streaming MD5 engine: at most one message byte per item, digest words A..D out
// after an item with last set. Items enter a small queue and are written to the
// block buffer one at a time; every 64th byte starts a compression (read the
// 64-byte buffer into the message words, 64 rounds at one per cycle, fold into
// the chain), and the queue is not popped again until it is done. Closing a
// message costs the padding writes plus one or two compressions before the four
// words appear.
module md5_hash_engine_unit import md5_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  md5_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output md5_out_t out_data
);
  logic    q_full, q_empty, q_pop;
  md5_in_t q_data;

  assign in_stall = q_full;

  md5_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst_n, .push(in_valid), .push_data(in_data), .full(q_full),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty)
  );

  md5_core u_core (
    .clk, .rst_n, .q_empty, .q_data, .q_pop, .out_valid, .out_stall, .out_data
  );
endmodule

FILE: src/md5_checker.sv
`include "md5_hash_engine_unit_assert.svh"
module md5_checker import md5_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input md5_out_t out_data
);
  `MD5_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, out_data.last_word == (out_data.word_index == 2'd3), "last_word mismatch")
  `MD5_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled word changed")
  `MD5_ASSERT_NXT(a_order, clk, rst_n, out_valid && !out_stall && out_data.word_index != 2'd3, out_valid && out_data.word_index == $past(out_data.word_index) + 2'd1, "word order broken")
endmodule

bind md5_hash_engine_unit md5_checker u_md5_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_data
);

FILE: tb/sv/md5_hash_engine_unit_test.sv
`timescale 1ns / 1ps

module md5_hash_engine_unit_test;
  import md5_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  md5_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  md5_out_t out_data;

  md5_hash_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Predictor state
  logic [31:0] chain[4];
  logic [7:0]  blk[64];
  int unsigned fill;
  logic [63:0] nbits;

  md5_out_t    digest_q[$];
  int unsigned fail_count;
  int unsigned word_count;
  int unsigned msg_count;
  int unsigned cycle_count;
  bit          idle_on;
  bit          hold_out;
  int unsigned hold_cycles;

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic compress();
    logic [31:0] m[16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned wi;
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 16; r++)
      m[r] = {blk[4*r+3], blk[4*r+2], blk[4*r+1], blk[4*r]};
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d); wi = r;
      end else if (r < 32) begin
        f = (b & d) | (c & ~d); wi = (5*r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d; wi = (3*r + 5) % 16;
      end else begin
        f = c ^ (b | ~d); wi = (7*r) % 16;
      end
      t = a + f + round_k(6'(r)) + m[wi];
      a = d; d = c; c = b;
      b = b + rotl(t, round_s(6'(r)));
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic digest_reset();
    chain[0] = InitA; chain[1] = InitB; chain[2] = InitC; chain[3] = InitD;
    fill = 0;
    nbits = '0;
  endtask

  task automatic predict_item(md5_in_t it);
    md5_out_t w;
    if (it.has_byte) begin
      blk[fill] = it.msg_byte;
      fill++;
      nbits += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!it.last) return;
    blk[fill] = PadByte;
    for (int k = fill + 1; k < 64; k++) blk[k] = 8'h00;
    if (fill >= 56) begin
      compress();
      for (int k = 0; k < 64; k++) blk[k] = 8'h00;
    end
    for (int k = 0; k < 8; k++) blk[56+k] = nbits[8*k +: 8];
    compress();
    for (int k = 0; k < 4; k++) begin
      w.digest_word = chain[k];
      w.word_index  = 2'(k);
      w.last_word   = (k == 3);
      digest_q.push_back(w);
    end
    msg_count++;
    digest_reset();
  endtask

  task automatic send_item(logic [7:0] b, bit hb, bit lst);
    md5_in_t it;
    it.msg_byte = b;
    it.has_byte = hb;
    it.last     = lst;
    while (idle_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  task automatic send_message(int unsigned len, bit tail_byte, bit rand_data);
    for (int unsigned i = 0; i < len; i++) begin
      if (tail_byte && i == len - 1)
        send_item(rand_data ? 8'($urandom) : 8'(i), 1'b1, 1'b1);
      else
        send_item(rand_data ? 8'($urandom) : 8'(i), 1'b1, 1'b0);
    end
    if (!tail_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Empty message, byte extremes, idle items, and byte with last together.
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b0);
    send_item(8'haa, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b1);
    drain();
  endtask

  // Pad byte right before the length field (55 bytes), and a full block
  // closed by its own last byte (64 bytes).
  task automatic test_pad_boundaries();
    send_message(55, 1'b0, 1'b1);
    send_message(64, 1'b1, 1'b0);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    hold_cycles = 400;
    hold_out = 1'b1;
    repeat (6) send_message($urandom_range(2), 1'($urandom_range(1)), 1'b1);
    in_valid <= 1'b0;
    do @(posedge clk); while (hold_out);
    drain();
  endtask

  task automatic test_random();
    int unsigned n;
    int unsigned sent;
    sent = 0;
    while (sent < 20) begin
      if ($urandom_range(9) == 0) begin
        send_item(8'($urandom), 1'b0, 1'b0);
        sent += 1;
      end else begin
        n = $urandom_range(4);
        send_message(n, 1'($urandom_range(1)), 1'b1);
        sent += n + 1;
      end
      if (sent > 10) idle_on = 1'b0;
    end
    idle_on = 1'b1;
    drain();
  endtask

  // Receiver stall: long hold-off on request, otherwise random while idle_on is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_out) begin
      out_stall <= 1'b1;
      if (hold_cycles == 0) hold_out <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= idle_on && ($urandom_range(99) < 22);
    end
  end

  always @(posedge clk) begin
    md5_out_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      word_count++;
      if (digest_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected digest word %h", $time, out_data);
      end else begin
        exp_w = digest_q.pop_front();
        if (out_data.digest_word !== exp_w.digest_word ||
            out_data.word_index !== exp_w.word_index ||
            out_data.last_word !== exp_w.last_word) begin
          fail_count++;
          $display("%0t: digest mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                   exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                   out_data.digest_word, out_data.word_index, out_data.last_word);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    idle_on     = 1'b1;
    hold_out    = 1'b0;
    hold_cycles = 0;
    fail_count  = 0;
    word_count  = 0;
    msg_count   = 0;
    cycle_count = 0;
    for (int k = 0; k < 64; k++) blk[k] = 8'h00;
    digest_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_random();
    $display("Hashed %0d messages, checked %0d digest words", msg_count, word_count);
    $display("Covered empty and boundary lengths, multi-block data, long output hold-off");
    if (fail_count == 0 && digest_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
